// File: sv/occt_pkg.sv
// Package for the order-1 context counter table.
// Holds the table geometry, the counter limit and the sequencer state type.
// No dependencies.
package occt_pkg;

  localparam int SYMBOL_BITS = 8;
  localparam int COUNT_BITS  = 16;
  localparam int SUM_BITS    = 24;

  localparam int ALPHABET = 1 << SYMBOL_BITS;
  localparam int PAIRS    = 1 << (2 * SYMBOL_BITS);

  localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = '1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WALK
  } occt_state_t;

endpackage

// File: sv/order1_context_counter_table.sv
// Top level of the order-1 context counter table.
// Holds the pair counter memory, the row sum memory and their sequencer.
// Depends on occt_pkg.

// A beat is taken on start while busy is low and answered by exactly one result beat,
// shown for one cycle with done high; the receiver cannot stall it. After reset the block
// runs a clearing pass over the pair counter memory, one entry per cycle, and busy stays
// high until all 2^(2*SYMBOL_BITS) entries (65536 at the default size) are cleared; the
// row sums are cleared in the same pass. An ordinary beat keeps the block busy until its
// write-back is done: the accept edge reads both memories, the next edge writes back the
// incremented counter and row sum through the single write port of each memory, so no new
// beat can be taken before that write-back. The result is registered at that same write
// edge. When a counter reaches the all-ones limit, the row is halved by a walk that reads
// and rewrites one entry per cycle through the same memory ports over all ALPHABET entries
// of the row (256 at the default size) before the result with row_rescaled set is shown.
module order1_context_counter_table
  import occt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  context_byte,
  input  logic [7:0]  symbol_byte,
  output logic        done,
  output logic [15:0] pair_count,
  output logic [23:0] row_total,
  output logic        row_rescaled
);

  localparam int SB = SYMBOL_BITS;
  localparam int KB = 2 * SYMBOL_BITS;

  // Memories. Read data is registered; one write port each.
  logic [COUNT_BITS-1:0] pair_mem [PAIRS];
  logic [SUM_BITS-1:0]   row_mem  [ALPHABET];

  logic [KB-1:0]         pair_raddr;
  logic [KB-1:0]         pair_waddr;
  logic [COUNT_BITS-1:0] pair_wdata;
  logic                  pair_we;
  logic [COUNT_BITS-1:0] pair_rd;

  logic [SB-1:0]         row_waddr;
  logic [SUM_BITS-1:0]   row_wdata;
  logic                  row_we;
  logic [SUM_BITS-1:0]   row_rd;

  occt_state_t state, state_next;

  // Clearing pass address.
  logic [KB-1:0] clr;
  // The latched beat.
  logic [SB-1:0] row;
  logic [SB-1:0] sym;
  // Walk: read index runs one ahead of the write index.
  logic [SB:0]   idx;
  logic          pend;
  logic [SB-1:0] pend_idx;
  logic [SUM_BITS-1:0] acc;

  logic [SB-1:0]         ctx_m;
  logic [SB-1:0]         sym_m;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  rescale;
  logic [COUNT_BITS-1:0] walk_val;
  logic [COUNT_BITS-1:0] halved;
  logic                  walk_rd;
  logic                  walk_last;

  assign ctx_m = context_byte[SB-1:0];
  assign sym_m = symbol_byte[SB-1:0];

  assign cnt_inc = pair_rd + 1'b1;
  assign rescale = (cnt_inc == COUNT_LIMIT);

  // The counter that hit the limit was never written back, so the walk substitutes it.
  assign walk_val  = (pend_idx == sym) ? COUNT_LIMIT : pair_rd;
  assign halved    = walk_val >> 1;
  assign walk_rd   = (idx < (SB+1)'(ALPHABET));
  assign walk_last = pend && (pend_idx == '1);

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pair_raddr = {ctx_m, sym_m};
    pair_we    = 1'b0;
    pair_waddr = {row, sym};
    pair_wdata = cnt_inc;
    row_we     = 1'b0;
    row_waddr  = row;
    row_wdata  = row_rd + 1'b1;
    case (state)
      ST_CLEAR: begin
        pair_we    = 1'b1;
        pair_waddr = clr;
        pair_wdata = '0;
        row_we     = 1'b1;
        row_waddr  = clr[SB-1:0];
        row_wdata  = '0;
        if (clr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (rescale) begin
          state_next = ST_WALK;
        end else begin
          pair_we    = 1'b1;
          row_we     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_WALK: begin
        pair_raddr = {row, idx[SB-1:0]};
        pair_we    = pend;
        pair_waddr = {row, pend_idx};
        pair_wdata = halved;
        row_we     = walk_last;
        row_wdata  = acc + SUM_BITS'(halved);
        if (walk_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    pair_rd <= pair_mem[pair_raddr];
    if (pair_we) begin
      pair_mem[pair_waddr] <= pair_wdata;
    end
  end

  always_ff @(posedge clk) begin
    row_rd <= row_mem[ctx_m];
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr  <= '0;
      idx  <= '0;
      pend <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr <= clr + 1'b1;
        end
        ST_READ: begin
          done <= !rescale;
          idx  <= '0;
          pend <= 1'b0;
        end
        ST_WALK: begin
          pend <= walk_rd;
          if (walk_rd) begin
            idx <= idx + 1'b1;
          end
          if (walk_last) begin
            done <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          row <= ctx_m;
          sym <= sym_m;
        end
      end
      ST_READ: begin
        pair_count   <= 16'(pair_rd);
        row_total    <= row_rd;
        row_rescaled <= 1'b0;
        acc          <= '0;
      end
      ST_WALK: begin
        pend_idx <= idx[SB-1:0];
        if (pend) begin
          acc <= acc + SUM_BITS'(halved);
        end
        if (walk_last) begin
          row_rescaled <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: sv/occt_checker.sv
// Port-level checker for the order-1 context counter table, with its bind.
// Depends on occt_pkg and on the top level order1_context_counter_table.
module occt_checker
  import occt_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [15:0] pair_count,
  input logic [23:0] row_total,
  input logic        row_rescaled
);

  // Reset always starts the clearing pass.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("block not busy after reset");

  // An accepted beat occupies the block and its result never comes on the next cycle.
  a_accept_then_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted beat did not hold the block busy");

  // A row total always covers the pair count that belongs to it.
  a_total_covers_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (row_total >= pair_count))
    else $error("row total below pair count");

  // Halving happens only when the counter was one short of the limit.
  a_rescale_at_limit: assert property (@(posedge clk) disable iff (rst)
    (done && row_rescaled) |-> (pair_count == 16'(COUNT_LIMIT - 1'b1)))
    else $error("row halved at wrong count");

endmodule

bind order1_context_counter_table occt_checker u_occt_checker (.*);
